// ----- rtl/thvn_pkg.sv -----
package thvn_pkg;

	localparam logic [31:0] HASH_MUL_X = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Z = 32'd668265263;
	localparam logic [31:0] HASH_MUL_SEED = 32'd2246822519;
	localparam logic [31:0] HASH_MIX = 32'd1274126177;
	localparam longint unsigned FREQ_STEP = 64'd133038;
	localparam int NOISE_LAT = 9;

	typedef enum logic [1:0] {
		REG_BASE_SCALE = 2'd0,
		REG_HILL_GAIN = 2'd1,
		REG_SWELL_SCALE = 2'd2,
		REG_SWELL_GAIN = 2'd3
	} cfg_reg_t;

	// octave frequency in Q16.16, 2.03^k with rounding at each step
	function automatic logic [31:0] freq_of(input int k);
		longint unsigned f;
		f = 64'd65536;
		for (int i = 0; i < k; i++) begin
			f = (f * FREQ_STEP + 64'd32768) >> 16;
		end
		return f[31:0];
	endfunction

	// seed contribution to the corner hash, mod 2^32
	function automatic logic [31:0] seed_term_of(input int seed);
		longint unsigned p;
		p = longint'(seed) * longint'(HASH_MUL_SEED);
		return p[31:0];
	endfunction

endpackage

// ----- rtl/thvn_noise.sv -----
module thvn_noise #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic signed [31:0]       wx,
	input  logic signed [31:0]       wz,
	input  logic [31:0]              scale,
	input  logic [31:0]              seed_term,
	output logic [FRACTION_BITS-1:0] n
);

	localparam int F = FRACTION_BITS;
	localparam int PW = 25 + F;
	localparam int SH = 40 - F;
	localparam int FW = F + 2;
	localparam int DW = 2 * F + 4;

	// stage 1: noise coordinate
	logic signed [64:0] prod_x, prod_z;
	logic [PW-1:0] px_s1, pz_s1;

	assign prod_x = wx * $signed({1'b0, scale});
	assign prod_z = wz * $signed({1'b0, scale});

	always_ff @(posedge clk) begin
		px_s1 <= PW'(prod_x >>> SH);
		pz_s1 <= PW'(prod_z >>> SH);
	end

	// stage 2: cell hash products, t squared
	logic [31:0] x0, z0;
	logic [F-1:0] tx, tz;
	logic [2*F-1:0] tsq_x, tsq_z;
	logic [31:0] mx_s2, mz_s2;
	logic [F-1:0] t2x_s2, t2z_s2, tx_s2, tz_s2;

	assign x0 = 32'($signed(px_s1[PW-1:F]));
	assign z0 = 32'($signed(pz_s1[PW-1:F]));
	assign tx = px_s1[F-1:0];
	assign tz = pz_s1[F-1:0];
	assign tsq_x = tx * tx;
	assign tsq_z = tz * tz;

	always_ff @(posedge clk) begin
		mx_s2 <= x0 * thvn_pkg::HASH_MUL_X;
		mz_s2 <= z0 * thvn_pkg::HASH_MUL_Z;
		t2x_s2 <= tsq_x[2*F-1:F];
		t2z_s2 <= tsq_z[2*F-1:F];
		tx_s2 <= tx;
		tz_s2 <= tz;
	end

	// stage 3: corner hash premix, fade
	logic [31:0] hpre [4];
	logic [FW-1:0] ux, uz;
	logic [F+FW-1:0] fpx, fpz;
	logic [31:0] hm_s3 [4];
	logic [FW-1:0] fx_s3, fz_s3;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			hpre[c] = mx_s2 + (c[0] ? thvn_pkg::HASH_MUL_X : 32'd0) + mz_s2
				+ (c[1] ? thvn_pkg::HASH_MUL_Z : 32'd0) + seed_term;
		end
	end

	assign ux = FW'(3 << F) - {1'b0, tx_s2, 1'b0};
	assign uz = FW'(3 << F) - {1'b0, tz_s2, 1'b0};
	assign fpx = t2x_s2 * ux;
	assign fpz = t2z_s2 * uz;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			hm_s3[c] <= hpre[c] ^ (hpre[c] >> 13);
		end
		fx_s3 <= fpx[F+FW-1:F];
		fz_s3 <= fpz[F+FW-1:F];
	end

	// stage 4: hash multiply
	logic [31:0] hp_s4 [4];
	logic [FW-1:0] fx_s4, fz_s4;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			hp_s4[c] <= hm_s3[c] * thvn_pkg::HASH_MIX;
		end
		fx_s4 <= fx_s3;
		fz_s4 <= fz_s3;
	end

	// stage 5: corner values in Q0.F
	logic [31:0] hf [4];
	logic [F-1:0] v_s5 [4];
	logic [FW-1:0] fx_s5, fz_s5;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			hf[c] = hp_s4[c] ^ (hp_s4[c] >> 16);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			v_s5[c] <= hf[c][23 -: F];
		end
		fx_s5 <= fx_s4;
		fz_s5 <= fz_s4;
	end

	// stage 6: x lerp products
	logic signed [F:0] dxa, dxb;
	logic signed [DW-1:0] pa_s6, pb_s6;
	logic [F-1:0] va_s6, vb_s6;
	logic [FW-1:0] fz_s6;

	assign dxa = $signed({1'b0, v_s5[1]}) - $signed({1'b0, v_s5[0]});
	assign dxb = $signed({1'b0, v_s5[3]}) - $signed({1'b0, v_s5[2]});

	always_ff @(posedge clk) begin
		pa_s6 <= dxa * $signed({1'b0, fx_s5});
		pb_s6 <= dxb * $signed({1'b0, fx_s5});
		va_s6 <= v_s5[0];
		vb_s6 <= v_s5[2];
		fz_s6 <= fz_s5;
	end

	// stage 7: x lerp sums
	logic signed [DW-1:0] la, lb;
	logic [F-1:0] a_s7, b_s7;
	logic [FW-1:0] fz_s7;

	assign la = $signed({{(DW-F){1'b0}}, va_s6}) + (pa_s6 >>> F);
	assign lb = $signed({{(DW-F){1'b0}}, vb_s6}) + (pb_s6 >>> F);

	always_ff @(posedge clk) begin
		a_s7 <= la[F-1:0];
		b_s7 <= lb[F-1:0];
		fz_s7 <= fz_s6;
	end

	// stage 8: z lerp product
	logic signed [F:0] dz;
	logic signed [DW-1:0] pz_s8;
	logic [F-1:0] a_s8;

	assign dz = $signed({1'b0, b_s7}) - $signed({1'b0, a_s7});

	always_ff @(posedge clk) begin
		pz_s8 <= dz * $signed({1'b0, fz_s7});
		a_s8 <= a_s7;
	end

	// stage 9: z lerp sum
	logic signed [DW-1:0] lz;
	logic [F-1:0] n_s9;

	assign lz = $signed({{(DW-F){1'b0}}, a_s8}) + (pz_s8 >>> F);

	always_ff @(posedge clk) begin
		n_s9 <= lz[F-1:0];
	end

	assign n = n_s9;

endmodule

// ----- rtl/terrain_height_value_noise_unit.sv -----
// Terrain height unit: fbm hill layer plus one swell layer of hashed value noise.
// Pipeline: 14 stages; done is the last bit of a valid pipe of the same depth.
// Throughput: one request per clock, busy is always low; all octaves run in parallel lanes.
// Results are not held: each one shows on height for the single cycle that done is high.
// Reset (arst_n low, async) clears the valid pipe and loads the config defaults.
module terrain_height_value_noise_unit #(
	parameter int OCTAVES = 5,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_z,
	output logic               done,
	output logic signed [24:0] height,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int F = FRACTION_BITS;
	localparam int LANES = OCTAVES + 1;            // last lane is the swell layer
	localparam int TOP_LAT = thvn_pkg::NOISE_LAT + 5;
	localparam int SW = F + OCTAVES;               // weighted octave sum width
	localparam int DIV = (1 << OCTAVES) - 1;       // total octave weight
	localparam int DIV_L = $clog2(DIV);
	localparam int DIV_SH = SW + DIV_L;
	localparam int MW = SW + 1;
	localparam longint unsigned DIV_M = ((64'd1 << DIV_SH) + DIV - 1) / DIV;
	localparam int LW = 26;                        // layer term width
	localparam logic signed [LW-1:0] H_MAX = LW'(16777215);
	localparam logic signed [LW-1:0] H_MIN = -LW'(16777216);

	// ---------------------------------------------------------------
	// Config registers
	// ---------------------------------------------------------------
	logic [23:0] base_scale_q, swell_scale_q;
	logic [15:0] hill_gain_q, swell_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_scale_q <= 24'd201327;
			hill_gain_q <= 16'd3584;
			swell_scale_q <= 24'd41943;
			swell_gain_q <= 16'd2560;
		end else if (cfg_we) begin
			case (cfg_index)
				thvn_pkg::REG_BASE_SCALE: base_scale_q <= cfg_data;
				thvn_pkg::REG_HILL_GAIN: hill_gain_q <= cfg_data[15:0];
				thvn_pkg::REG_SWELL_SCALE: swell_scale_q <= cfg_data;
				thvn_pkg::REG_SWELL_GAIN: swell_gain_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Fully pipelined: never back-pressures the requester.
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// Valid pipe: vld[i] marks stage i+1
	// ---------------------------------------------------------------
	logic [TOP_LAT-1:0] vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= {vld[TOP_LAT-2:0], start & ~busy};
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: per-octave scale = base_scale * 2.03^k, Q.24
	// ---------------------------------------------------------------
	logic signed [31:0] wx_s1, wz_s1;
	logic [31:0] sc_s1 [LANES];
	logic [55:0] scp [OCTAVES];

	always_comb begin
		for (int k = 0; k < OCTAVES; k++) begin
			scp[k] = {32'd0, base_scale_q} * {24'd0, thvn_pkg::freq_of(k)};
		end
	end

	always_ff @(posedge clk) begin
		wx_s1 <= world_x;
		wz_s1 <= world_z;
		for (int k = 0; k < OCTAVES; k++) begin
			sc_s1[k] <= scp[k][47:16];
		end
		sc_s1[OCTAVES] <= {8'd0, swell_scale_q};
	end

	// ---------------------------------------------------------------
	// Stages 2..10: one noise lane per octave plus the swell lane
	// ---------------------------------------------------------------
	logic [F-1:0] nz [LANES];

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		localparam int SEED = (g < OCTAVES) ? (g * 101 + 7) : 999;
		thvn_noise #(
			.FRACTION_BITS(F)
		) u_noise (
			.clk(clk),
			.wx(wx_s1),
			.wz(wz_s1),
			.scale(sc_s1[g]),
			.seed_term(thvn_pkg::seed_term_of(SEED)),
			.n(nz[g])
		);
	end

	// ---------------------------------------------------------------
	// Stage 11: octave k weighted by 2^(OCTAVES-1-k)
	// ---------------------------------------------------------------
	logic [SW-1:0] acc;
	logic [SW-1:0] sum_s11;
	logic [F-1:0] sw_s11;

	always_comb begin
		acc = '0;
		for (int k = 0; k < OCTAVES; k++) begin
			acc = acc + (SW'(nz[k]) << (OCTAVES - 1 - k));
		end
	end

	always_ff @(posedge clk) begin
		sum_s11 <= acc;
		sw_s11 <= nz[OCTAVES];
	end

	// ---------------------------------------------------------------
	// Stage 12: divide by 2^OCTAVES-1 via exact reciprocal multiply
	// ---------------------------------------------------------------
	logic [SW+MW-1:0] qprod;
	logic [F-1:0] fbm_s12, sw_s12;

	assign qprod = {{MW{1'b0}}, sum_s11} * {{SW{1'b0}}, MW'(DIV_M)};

	always_ff @(posedge clk) begin
		fbm_s12 <= qprod[DIV_SH +: F];
		sw_s12 <= sw_s11;
	end

	// ---------------------------------------------------------------
	// Stage 13: center and scale each layer into a signed Q10.16 term
	// ---------------------------------------------------------------
	logic signed [F:0] hill_cen, swell_cen;
	logic signed [F+17:0] hill_p, swell_p;
	logic signed [LW-1:0] hill_s13, swell_s13;

	assign hill_cen = $signed({1'b0, fbm_s12}) - $signed((F+1)'(1 << (F - 1)));
	assign swell_cen = $signed({1'b0, sw_s12}) - $signed((F+1)'(1 << (F - 1)));
	assign hill_p = hill_cen * $signed({1'b0, hill_gain_q});
	assign swell_p = swell_cen * $signed({1'b0, swell_gain_q});

	always_ff @(posedge clk) begin
		hill_s13 <= LW'(hill_p >>> (F - 8));
		swell_s13 <= LW'(swell_p >>> (F - 8));
	end

	// ---------------------------------------------------------------
	// Stage 14: add layers and saturate
	// ---------------------------------------------------------------
	logic signed [LW-1:0] hsum;
	logic signed [24:0] height_s14;

	assign hsum = hill_s13 + swell_s13;

	always_ff @(posedge clk) begin
		if (hsum > H_MAX) begin
			height_s14 <= H_MAX[24:0];
		end else if (hsum < H_MIN) begin
			height_s14 <= H_MIN[24:0];
		end else begin
			height_s14 <= hsum[24:0];
		end
	end

	assign height = height_s14;
	assign done = vld[TOP_LAT-1];

`ifndef SYNTHESIS
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(TOP_LAT) done)
		else $error("request did not produce a result");

	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOP_LAT))
		else $error("result without a matching request");

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[TOP_LAT-2] && hill_gain_q == 16'd0 && swell_gain_q == 16'd0
			&& !cfg_we) |=> (height == 25'sd0))
		else $error("zero gains gave nonzero height");
`endif

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_OCT = 5;
	localparam int FB = 16;
	localparam int PIPE_LAT = 13;
	localparam longint CYCLE_LIMIT = 400000;

	// predictor state: mirror of the config registers
	class height_scoreboard;
		logic [23:0] base_scale;
		logic [15:0] hill_gain;
		logic [23:0] swell_scale;
		logic [15:0] swell_gain;
		logic signed [24:0] pending[$];
		int errors;
		int mismatches;

		function void reset_regs();
			base_scale = 24'd201327;
			hill_gain = 16'd3584;
			swell_scale = 24'd41943;
			swell_gain = 16'd2560;
		endfunction

		function void write_reg(thvn_pkg::cfg_reg_t idx, logic [23:0] v);
			case (idx)
				thvn_pkg::REG_BASE_SCALE: base_scale = v;
				thvn_pkg::REG_HILL_GAIN: hill_gain = v[15:0];
				thvn_pkg::REG_SWELL_SCALE: swell_scale = v;
				thvn_pkg::REG_SWELL_GAIN: swell_gain = v[15:0];
				default: ;
			endcase
		endfunction

		// floor division by 2^n (>>> on signed longint floors)
		function longint fshr(longint v, int n);
			return v >>> n;
		endfunction

		function logic [31:0] mix(logic [31:0] x, logic [31:0] z, logic [31:0] seed);
			logic [31:0] h;
			h = x * 32'd374761393 + z * 32'd668265263 + seed * 32'd2246822519;
			h = (h ^ (h >> 13)) * 32'd1274126177;
			return h ^ (h >> 16);
		endfunction

		function longint corner(logic [31:0] x, logic [31:0] z, logic [31:0] seed);
			logic [31:0] h;
			h = mix(x, z, seed);
			return longint'({8'd0, h[23:0]} >> (24 - FB));
		endfunction

		function longint smooth(longint t);
			longint t2;
			t2 = (t * t) >>> FB;
			return (t2 * ((longint'(3) << FB) - 2 * t)) >>> FB;
		endfunction

		function longint blend(longint a, longint b, longint w);
			return a + fshr((b - a) * w, FB);
		endfunction

		function longint noise2d(longint wx, longint wz, longint sc, logic [31:0] seed);
			longint px, pz, tx, tz, a, b;
			logic [31:0] x0, z0;
			px = fshr(wx * sc, 40 - FB);
			pz = fshr(wz * sc, 40 - FB);
			x0 = 32'(fshr(px, FB));
			z0 = 32'(fshr(pz, FB));
			tx = smooth(px & ((longint'(1) << FB) - 1));
			tz = smooth(pz & ((longint'(1) << FB) - 1));
			a = blend(corner(x0, z0, seed), corner(x0 + 1, z0, seed), tx);
			b = blend(corner(x0, z0 + 1, seed), corner(x0 + 1, z0 + 1, seed), tx);
			return blend(a, b, tz);
		endfunction

		function longint amplify(longint n, logic [15:0] gain);
			return fshr((n - (longint'(1) << (FB - 1))) * longint'({1'b0, gain}), FB - 8);
		endfunction

		// note an accepted request: compute its height
		function void note_request(logic signed [31:0] x, logic signed [31:0] z);
			longint unsigned f;
			longint sum, fbm, h, sc;
			f = 65536;
			sum = 0;
			for (int k = 0; k < N_OCT; k++) begin
				sc = longint'((longint'(base_scale) * f) >> 16);
				sum += noise2d(longint'(x), longint'(z), sc, 32'(k * 101 + 7))
					<< (N_OCT - 1 - k);
				f = (f * 133038 + 32768) >> 16;
			end
			fbm = sum / ((longint'(1) << N_OCT) - 1);
			h = amplify(fbm, hill_gain) + amplify(noise2d(longint'(x), longint'(z),
				longint'(swell_scale), 32'd999), swell_gain);
			if (h > 16777215) h = 16777215;
			if (h < -16777216) h = -16777216;
			pending.insert(pending.size(), 25'(h));
		endfunction

		function void check_height(logic signed [24:0] got);
			logic signed [24:0] exp_h;
			if (pending.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result height=%0d", got);
				return;
			end
			exp_h = pending.pop_front();
			if (got !== exp_h) begin
				errors++;
				if (mismatches++ < 10)
					$display("height mismatch: expected %0d, got %0d", exp_h, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [31:0] world_x = 0;
	logic signed [31:0] world_z = 0;
	logic done;
	logic signed [24:0] height;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [23:0] cfg_data = 0;

	height_scoreboard sb;
	longint cycles = 0;

	always #1 clk = ~clk;

	terrain_height_value_noise_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.world_x(world_x), .world_z(world_z), .done(done), .height(height),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// sample at rising edge: accepted requests feed the predictor, results get checked
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (start && !busy) sb.note_request(world_x, world_z);
			if (done) sb.check_height(height);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
		repeat (n) @(negedge clk);
	endtask

	// hold start until the request is taken, then drop it unless another follows
	task automatic send_request(logic signed [31:0] x, logic signed [31:0] z,
			bit keep_going);
		world_x <= x;
		world_z <= z;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		if (!keep_going) begin
			start <= 0;
			@(negedge clk);
		end
	endtask

	task automatic write_cfg(thvn_pkg::cfg_reg_t idx, logic [23:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, v);
		@(negedge clk);
	endtask

	// wait for the pipe to drain, plus the latency margin
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000) << 8;
			2: return 32'($signed($urandom_range(0, 200000)) - 100000) << 16;
			default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	task automatic random_burst(int count);
		for (int i = 0; i < count; i++) begin
			bit chain;
			chain = ($urandom_range(0, 2) != 0) && (i != count - 1);
			send_request(rand_coord(), rand_coord(), chain);
			if (!chain) idle_gap();
		end
	endtask

	logic signed [31:0] corners[8] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1,
		32'sh0001_0000, 32'shffff_0000, 32'sh0000_8000};

	initial begin
		sb = new();
		sb.reset_regs();
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: extreme coordinates at reset settings
		for (int i = 0; i < 8; i++) send_request(corners[i], corners[7 - i], i != 7);
		for (int i = 0; i < 4; i++) send_request(corners[i], corners[i], 0);
		drain();

		// zero scales give constant layers; max gains push toward saturation
		write_cfg(thvn_pkg::REG_BASE_SCALE, 24'd0);
		write_cfg(thvn_pkg::REG_SWELL_SCALE, 24'd0);
		write_cfg(thvn_pkg::REG_HILL_GAIN, 24'hffffff);
		write_cfg(thvn_pkg::REG_SWELL_GAIN, 24'hffffff);
		for (int i = 0; i < 4; i++) send_request(corners[i], corners[i + 2], 0);
		drain();
		write_cfg(thvn_pkg::REG_BASE_SCALE, 24'hffffff);
		write_cfg(thvn_pkg::REG_SWELL_SCALE, 24'hffffff);
		for (int i = 0; i < 8; i++) send_request(corners[i], corners[(i + 3) % 8], i != 7);
		drain();

		// random phases across several settings
		for (int p = 0; p < 8; p++) begin
			write_cfg(thvn_pkg::REG_BASE_SCALE, 24'((p % 3 == 0) ? 32'd1 : $urandom()));
			write_cfg(thvn_pkg::REG_HILL_GAIN, 24'((p == 1) ? 32'd0 : $urandom()));
			write_cfg(thvn_pkg::REG_SWELL_SCALE,
				24'((p == 2) ? 32'h00ff_ffff : $urandom()));
			write_cfg(thvn_pkg::REG_SWELL_GAIN, 24'($urandom()));
			random_burst(95);
			// hold off until every outstanding height is back
			drain();
		end
		write_cfg(thvn_pkg::REG_BASE_SCALE, 24'd201327);
		write_cfg(thvn_pkg::REG_HILL_GAIN, 24'd3584);
		write_cfg(thvn_pkg::REG_SWELL_SCALE, 24'd41943);
		write_cfg(thvn_pkg::REG_SWELL_GAIN, 24'd2560);
		random_burst(20);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/thvn_pkg.sv
rtl/thvn_noise.sv
rtl/terrain_height_value_noise_unit.sv
tb/tb.sv
